[sv/gbp_pkg.sv]
// shared types and constants of the gshare branch predictor
// no dependencies; imported by the interfaces and every module

package gbp_pkg;

  // field widths fixed by the channel format
  localparam int PC_BITS  = 12;
  localparam int OUT_BITS = 32;

  // defaults for the top level parameters
  localparam int HISTORY_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF   = 32;

  // two-bit saturating counter
  typedef logic [1:0] ctr_t;
  localparam ctr_t CTR_MIN        = 2'd0;
  localparam ctr_t CTR_WEAK_TAKEN = 2'd2;
  localparam ctr_t CTR_MAX        = 2'd3;

  // action codes
  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_UPDATE  = 1'b1;

  // predictor mode codes
  localparam logic MODE_ALWAYS_TAKEN = 1'b0;
  localparam logic MODE_GSHARE       = 1'b1;
  localparam logic MODE_RESET        = MODE_GSHARE;

  // increment requests to the statistics counters
  typedef struct packed {
    logic branch;
    logic mispredict;
  } stat_req_t;

  // counter moved one step toward the outcome
  function automatic ctr_t ctr_train(input ctr_t c, input logic taken);
    ctr_t r;
    r = c;
    if (taken) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

[sv/gbp_ifs.sv]
// valid/ready channel interfaces for request and response beats
// depends on gbp_pkg for the field widths

interface gbp_req_if import gbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [PC_BITS-1:0] pc_low;
  logic               prior_prediction;
  logic               outcome_taken;

  modport source (output valid, action, pc_low, prior_prediction, outcome_taken,
                  input ready);
  modport sink   (input valid, action, pc_low, prior_prediction, outcome_taken,
                  output ready);
endinterface

interface gbp_rsp_if import gbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                predicted_taken;
  logic [OUT_BITS-1:0] branch_total;
  logic [OUT_BITS-1:0] mispredict_total;

  modport source (output valid, predicted_taken, branch_total, mispredict_total,
                  input ready);
  modport sink   (input valid, predicted_taken, branch_total, mispredict_total,
                  output ready);
endinterface

[sv/gshare_branch_predictor_unit.sv]
// top level of the gshare branch predictor: history, pipeline, output register
// depends on gbp_pkg, gbp_ifs, gbp_table and gbp_stats
//
//   channel  role    beat contents
//   req      sink    action, pc_low, prior_prediction, outcome_taken
//   rsp      source  predicted_taken, branch_total, mispredict_total
//   cfg      write   predictor_mode in cfg_data[0] when cfg_write is high
//
// one beat a cycle while neither a stall on rsp nor the sweep holds req.ready low;
// a result goes through the read stage (table read), then counter check and write-back into the output register
// after reset every table entry is swept to weakly taken, and
// req.ready stays low during the sweep
// a stall on rsp holds the output register and then the read stage

module gshare_branch_predictor_unit import gbp_pkg::*; #(
  parameter int HISTORY_BITS = HISTORY_BITS_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  gbp_req_if.sink   req,
  gbp_rsp_if.source rsp,
  input  logic      cfg_write,
  input  logic      cfg_data
);

  logic                    mode;
  logic [HISTORY_BITS-1:0] history;
  logic                    accept, s1_go, tbl_busy;
  logic [HISTORY_BITS+PC_BITS-1:0] pc_wide;
  logic [HISTORY_BITS-1:0] idx;
  stat_req_t               stat_req;
  logic [OUT_BITS-1:0]     branch_total, mispredict_total;

  // read stage
  logic                    s1_valid;
  logic                    s1_action;
  logic                    s1_taken;
  logic                    s1_gshare;
  logic [HISTORY_BITS-1:0] s1_idx;
  logic [OUT_BITS-1:0]     s1_btot, s1_mtot;
  ctr_t                    rd_data, ctr_cur, ctr_new;
  logic                    s1_train;

  // write forwarding for back-to-back hits on one entry
  logic                    fwd_valid;
  logic [HISTORY_BITS-1:0] fwd_idx;
  ctr_t                    fwd_val;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (cfg_write) begin
      mode <= cfg_data;
    end
  end

  // handshake
  assign s1_go     = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !rst && !tbl_busy && (!s1_valid || s1_go);
  assign accept    = req.valid && req.ready;

  // table index from pc and history
  assign pc_wide = {{HISTORY_BITS{1'b0}}, req.pc_low};
  assign idx     = pc_wide[HISTORY_BITS-1:0] ^ history;

  // history shifts on an update beat in gshare mode
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (accept && req.action == ACT_UPDATE && mode == MODE_GSHARE) begin
      history <= {history[HISTORY_BITS-2:0], req.outcome_taken};
    end
  end

  // statistics on each update beat
  always_comb begin
    stat_req.branch     = accept && req.action == ACT_UPDATE;
    stat_req.mispredict = stat_req.branch && (req.prior_prediction != req.outcome_taken);
  end

  gbp_stats #(
    .COUNT_BITS(COUNT_BITS)
  ) u_stats (
    .clk              (clk),
    .rst              (rst),
    .req              (stat_req),
    .branch_total     (branch_total),
    .mispredict_total (mispredict_total)
  );

  // counter memory
  gbp_table #(
    .HISTORY_BITS(HISTORY_BITS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_idx  (idx),
    .rd_data (rd_data),
    .wr_en   (s1_go && s1_train),
    .wr_idx  (s1_idx),
    .wr_data (ctr_new),
    .busy    (tbl_busy)
  );

  // read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= req.action;
      s1_taken  <= req.outcome_taken;
      s1_gshare <= (mode == MODE_GSHARE);
      s1_idx    <= idx;
      s1_btot   <= branch_total;
      s1_mtot   <= mispredict_total;
    end
  end

  // counter check and training, with the previous beat's write forwarded
  assign ctr_cur  = (fwd_valid && fwd_idx == s1_idx) ? fwd_val : rd_data;
  assign ctr_new  = ctr_train(ctr_cur, s1_taken);
  assign s1_train = s1_gshare && s1_action == ACT_UPDATE;

  // forward only when a write and the next read land on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (accept) begin
      fwd_valid <= s1_go && s1_train;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_idx <= s1_idx;
      fwd_val <= ctr_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      if (s1_action == ACT_UPDATE) begin
        rsp.predicted_taken <= 1'b0;
      end else if (s1_gshare) begin
        rsp.predicted_taken <= ctr_cur[1];
      end else begin
        rsp.predicted_taken <= 1'b1;
      end
      rsp.branch_total     <= s1_btot;
      rsp.mispredict_total <= s1_mtot;
    end
  end

endmodule

[sv/gbp_table.sv]
// counter table: one-read one-write synchronous memory with a clearing sweep
// depends on gbp_pkg for the counter type and reset value

module gbp_table import gbp_pkg::*; #(
  parameter int HISTORY_BITS = HISTORY_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [HISTORY_BITS-1:0] rd_idx,
  output ctr_t                    rd_data,
  input  logic                    wr_en,
  input  logic [HISTORY_BITS-1:0] wr_idx,
  input  ctr_t                    wr_data,
  output logic                    busy
);

  localparam int DEPTH = 1 << HISTORY_BITS;

  ctr_t                    mem [DEPTH];
  logic [HISTORY_BITS-1:0] clr_idx;
  logic                    clearing;

  // clearing sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == {HISTORY_BITS{1'b1}}) clearing <= 1'b0;
    end
  end

  assign busy = clearing;

  // single write port shared by sweep and training
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= CTR_WEAK_TAKEN;
    end else if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_idx];
  end

endmodule

[sv/gbp_stats.sv]
// saturating branch and mispredict counters
// depends on gbp_pkg for the request struct and output width

module gbp_stats import gbp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  stat_req_t           req,
  output logic [OUT_BITS-1:0] branch_total,
  output logic [OUT_BITS-1:0] mispredict_total
);

  logic [COUNT_BITS-1:0]          branch_count, branch_count_next;
  logic [COUNT_BITS-1:0]          mispredict_count, mispredict_count_next;
  logic [COUNT_BITS+OUT_BITS-1:0] branch_wide, mispredict_wide;

  // next values, stopping at all ones
  always_comb begin
    branch_count_next     = branch_count;
    mispredict_count_next = mispredict_count;
    if (req.branch && branch_count != {COUNT_BITS{1'b1}})
      branch_count_next = branch_count + 1'b1;
    if (req.mispredict && mispredict_count != {COUNT_BITS{1'b1}})
      mispredict_count_next = mispredict_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      branch_count     <= '0;
      mispredict_count <= '0;
    end else begin
      branch_count     <= branch_count_next;
      mispredict_count <= mispredict_count_next;
    end
  end

  // totals after this beat, low bits onto the output width
  assign branch_wide      = {{OUT_BITS{1'b0}}, branch_count_next};
  assign mispredict_wide  = {{OUT_BITS{1'b0}}, mispredict_count_next};
  assign branch_total     = branch_wide[OUT_BITS-1:0];
  assign mispredict_total = mispredict_wide[OUT_BITS-1:0];

endmodule

[dv/testbench.sv]
// self-checking bench for gshare_branch_predictor_unit: directed and random beats,
// each response checked against an in-bench model of the table, history and counts
// depends on gbp_pkg, gbp_ifs and the predictor rtl

module testbench import gbp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_BITS    = HISTORY_BITS_DEF;
  localparam int TABLE_DEPTH  = 1 << HIST_BITS;
  localparam int IDLE_PCT     = 37;
  localparam int LIMIT_CYCLES = 200_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOT_PCS      = 6;
  localparam logic [HIST_BITS-1:0] SAT_IDX = 12'h5a5;

  typedef struct packed {
    logic                taken;
    logic [OUT_BITS-1:0] branches;
    logic [OUT_BITS-1:0] misses;
  } result_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_data;
  logic calm;

  gbp_req_if req_ch ();
  gbp_rsp_if rsp_ch ();

  gshare_branch_predictor_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // mirror of the predictor state
  ctr_t                  pht [TABLE_DEPTH];
  logic [HIST_BITS-1:0]  ghist;
  logic [OUT_BITS-1:0]   n_branch;
  logic [OUT_BITS-1:0]   n_miss;
  logic                  mode;

  result_t               pending_rsp [$];
  logic [PC_BITS-1:0]    hot_pc [HOT_PCS];

  int errors;
  int n_pred;
  int n_upd;
  int n_checked;
  int n_mode_writes;
  int cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected response of one accepted beat, advancing the mirror state
  function automatic result_t predict_and_train(input logic act,
                                                input logic [PC_BITS-1:0] pc,
                                                input logic prior,
                                                input logic taken);
    result_t r;
    logic [HIST_BITS-1:0] idx;
    idx = pc ^ ghist;
    r.taken = 1'b0;
    if (act == ACT_PREDICT) begin
      r.taken = (mode == MODE_GSHARE) ? (pht[idx] >= CTR_WEAK_TAKEN) : 1'b1;
    end else begin
      if (n_branch != '1) n_branch = n_branch + 1'b1;
      if (prior != taken && n_miss != '1) n_miss = n_miss + 1'b1;
      if (mode == MODE_GSHARE) begin
        if (taken && pht[idx] != CTR_MAX) pht[idx] = pht[idx] + 2'd1;
        else if (!taken && pht[idx] != CTR_MIN) pht[idx] = pht[idx] - 2'd1;
        ghist = {ghist[HIST_BITS-2:0], taken};
      end
    end
    r.branches = n_branch;
    r.misses   = n_miss;
    return r;
  endfunction

  // one request beat; returns the expected prediction of that beat
  task automatic push_beat(input logic act, input logic [PC_BITS-1:0] pc,
                           input logic prior, input logic taken, output logic guess);
    result_t r;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.action           <= act;
    req_ch.pc_low           <= pc;
    req_ch.prior_prediction <= prior;
    req_ch.outcome_taken    <= taken;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = predict_and_train(act, pc, prior, taken);
    pending_rsp.push_back(r);
    guess = r.taken;
    if (act == ACT_PREDICT) n_pred++;
    else n_upd++;
  endtask

  // beats aimed at one table entry under the current history
  task automatic predict_at(input logic [HIST_BITS-1:0] idx);
    logic g;
    push_beat(ACT_PREDICT, PC_BITS'(idx ^ ghist), 1'b0, 1'b1, g);
  endtask

  task automatic resolve_at(input logic [HIST_BITS-1:0] idx, input logic prior,
                            input logic taken);
    logic g;
    push_beat(ACT_UPDATE, PC_BITS'(idx ^ ghist), prior, taken, g);
  endtask

  // stop sending and wait for every outstanding response
  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // mode register write while the block is idle
  task automatic write_mode(input logic m);
    drain_results();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(negedge clk);
    cfg_write <= 1'b0;
    mode = m;
    n_mode_writes++;
  endtask

  // predictions at both pc extremes, update-only fields set to junk
  task automatic test_predict_extremes();
    logic g;
    push_beat(ACT_PREDICT, '0, 1'b1, 1'b1, g);
    push_beat(ACT_PREDICT, '1, 1'b0, 1'b0, g);
    push_beat(ACT_PREDICT, 12'h555, 1'b1, 1'b0, g);
    push_beat(ACT_PREDICT, 12'haaa, 1'b0, 1'b1, g);
  endtask

  // drive one counter into both saturation points, all prior/outcome pairs
  task automatic test_counter_saturation();
    resolve_at(SAT_IDX, 1'b1, 1'b1);
    resolve_at(SAT_IDX, 1'b0, 1'b1);
    predict_at(SAT_IDX);
    resolve_at(SAT_IDX, 1'b1, 1'b0);
    resolve_at(SAT_IDX, 1'b0, 1'b0);
    resolve_at(SAT_IDX, 1'b1, 1'b0);
    resolve_at(SAT_IDX, 1'b1, 1'b0);
    predict_at(SAT_IDX);
  endtask

  // always-taken mode counts only; table and history survive the switch back
  task automatic test_mode_switch();
    write_mode(MODE_ALWAYS_TAKEN);
    predict_at(SAT_IDX);
    resolve_at(SAT_IDX, 1'b1, 1'b0);
    resolve_at(SAT_IDX, 1'b0, 1'b1);
    write_mode(MODE_GSHARE);
    predict_at(SAT_IDX);
  endtask

  // mostly predict-then-resolve pairs on a few hot branches, some noise beats
  task automatic test_random_traffic(input int n_items, input int calm_from,
                                     input int calm_to);
    int sent;
    int slot;
    logic [PC_BITS-1:0] pc;
    logic guess;
    logic outcome;
    logic prior;
    logic g;
    sent = 0;
    while (sent < n_items) begin
      calm = (sent >= calm_from && sent < calm_to);
      if ($urandom_range(0, 99) < 80) begin
        slot = $urandom_range(0, HOT_PCS - 1);
        pc   = hot_pc[slot];
        push_beat(ACT_PREDICT, pc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  guess);
        // even slots lean taken, odd slots lean not taken
        outcome = ($urandom_range(0, 99) < ((slot % 2 == 0) ? 85 : 15));
        prior   = ($urandom_range(0, 9) == 0) ? !guess : guess;
        push_beat(ACT_UPDATE, pc, prior, outcome, g);
        sent += 2;
      end else begin
        push_beat(1'($urandom_range(0, 1)), PC_BITS'($urandom_range(0, TABLE_DEPTH - 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), g);
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // response side backpressure
  always @(negedge clk) begin
    rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic check_field(input string name, input logic [OUT_BITS-1:0] want,
                             input logic [OUT_BITS-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // compare each response beat with the oldest expectation
  always @(posedge clk) begin : check_rsp
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response beat, expected none actual %0h/%0h/%0h",
                 $time, rsp_ch.predicted_taken, rsp_ch.branch_total,
                 rsp_ch.mispredict_total);
      end else begin
        want = pending_rsp.pop_front();
        n_checked++;
        check_field("predicted_taken", OUT_BITS'(want.taken),
                    OUT_BITS'(rsp_ch.predicted_taken));
        check_field("branch_total", want.branches, rsp_ch.branch_total);
        check_field("mispredict_total", want.misses, rsp_ch.mispredict_total);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
      $display("tb: failure");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst                     = 1'b1;
    calm                    = 1'b0;
    cfg_write               = 1'b0;
    cfg_data                = 1'b0;
    req_ch.valid            = 1'b0;
    req_ch.action           = ACT_PREDICT;
    req_ch.pc_low           = '0;
    req_ch.prior_prediction = 1'b0;
    req_ch.outcome_taken    = 1'b0;
    rsp_ch.ready            = 1'b0;
    errors        = 0;
    n_pred        = 0;
    n_upd         = 0;
    n_checked     = 0;
    n_mode_writes = 0;
    cycle_count   = 0;
    foreach (pht[i]) pht[i] = CTR_WEAK_TAKEN;
    ghist    = '0;
    n_branch = '0;
    n_miss   = '0;
    mode     = MODE_RESET;
    hot_pc[0] = '0;
    hot_pc[1] = '1;
    for (int i = 2; i < HOT_PCS; i++) hot_pc[i] = PC_BITS'($urandom_range(0, TABLE_DEPTH - 1));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_predict_extremes();
    test_counter_saturation();
    test_mode_switch();
    test_random_traffic(300, 120, 180);
    write_mode(MODE_ALWAYS_TAKEN);
    test_random_traffic(60, 0, 0);
    write_mode(MODE_GSHARE);
    test_random_traffic(140, 0, 0);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d predict and %0d update beats over %0d mode writes",
             n_pred, n_upd, n_mode_writes);
    $display("%0d response beats checked, %0d mismatches", n_checked, errors);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/gbp_pkg.sv
sv/gbp_ifs.sv
sv/gbp_table.sv
sv/gbp_stats.sv
sv/gshare_branch_predictor_unit.sv
dv/testbench.sv
